/* rtl/core/bic_pkg.sv */
// ---------------------------------------------------------------------------
// bic_pkg
// Shared types and constants for the BIC window update block.
// ---------------------------------------------------------------------------
package bic_pkg;

  localparam int unsigned SmoothPartDefault = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW = 88;   // kind 2 + cwnd 32 + ssth 32 + acked 16 = 82 -> 88
  localparam int unsigned OutDataW = 96;
  localparam logic [31:0] CapLowMax = 32'd20;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_LOSS   = 2'd1,
    KIND_REDUCE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_AVG  = 3'd0,
    REG_MIN  = 3'd1,
    REG_SEG  = 3'd2,
    REG_LOW  = 3'd3,
    REG_MINC = 3'd4,
    REG_DIV  = 3'd5,
    REG_BETA = 3'd6,
    REG_FC   = 3'd7
  } reg_idx_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture item
    OP_SEGDIV,    // start segs = cwnd / seg_size
    OP_SEGDONE,   // capture segs and path decisions
    OP_DISTDIV,   // start dist = (lm - s) / b
    OP_DISTDONE,
    OP_CNTDIV,    // start count division by chosen operands
    OP_CNTDONE,
    OP_FINISH     // form result, update state
  } op_t;

  typedef struct packed {
    op_t op;
  } bic_cmd_t;

  typedef struct packed {
    logic   div_busy;
    kind_t  kind;
    logic   is_ack_grow;  // ack that runs the growth step
    logic   low_path;     // seg below low segment count
    logic   need_dist;    // s < lm
  } bic_sts_t;

endpackage

/* rtl/core/bic_div.sv */
// ---------------------------------------------------------------------------
// bic_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ---------------------------------------------------------------------------
module bic_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);
  logic [6:0]  cnt;
  logic [32:0] rem;
  logic [63:0] q;
  logic [31:0] dv;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[63]};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
      q    <= dividend;
      dv   <= divisor;
      rem  <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, dv}) begin
        rem <= trial - {1'b0, dv};
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

/* rtl/core/bic_dp.sv */
// ---------------------------------------------------------------------------
// bic_dp
// Datapath: config registers, state, operand selection and shared divider.
// ---------------------------------------------------------------------------
module bic_dp #(
  parameter int unsigned SMOOTH_PART = bic_pkg::SmoothPartDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bic_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [bic_pkg::CfgDataW-1:0]  cfg_data,
  input  logic [bic_pkg::InDataW-1:0]   in_data,
  input  bic_pkg::bic_cmd_t             cmd,
  output bic_pkg::bic_sts_t             sts,
  output logic [bic_pkg::OutDataW-1:0]  out_data
);
  import bic_pkg::*;

  logic [31:0] avg_w, min_w;
  logic [15:0] seg_sz, low_segs, max_inc;
  logic [7:0]  sdiv;
  logic [8:0]  beta;
  logic        fc_on;

  logic        started;
  logic [31:0] acc;
  logic [31:0] last_max;

  kind_t       kind;
  logic [31:0] cwnd, ssth;
  logic [15:0] acked;
  logic [31:0] segs;
  logic [63:0] gap;
  logic [63:0] cnt;
  logic        grow;
  logic        low_p, need_d;

  logic        div_start, div_busy;
  logic [63:0] div_a, div_q;
  logic [31:0] div_b;

  logic [31:0] b_eff, mi_eff;
  logic [63:0] lm_b, lm_mib;
  logic [23:0] mib_prod;
  logic [39:0] sb_prod;
  logic [63:0] s_smooth;
  logic [41:0] beta_prod;

  assign b_eff  = (sdiv < 8'd2) ? 32'd2 : {24'd0, sdiv};
  assign mi_eff = (max_inc == 16'd0) ? 32'd1 : {16'd0, max_inc};
  assign lm_b   = {32'd0, last_max} + {32'd0, b_eff};
  assign mib_prod = mi_eff[15:0] * (b_eff[7:0] - 8'd1);
  assign lm_mib = {32'd0, last_max} + {40'd0, mib_prod};
  assign sb_prod = segs * (b_eff[7:0] - 8'd1);
  assign s_smooth = {32'd0, segs} * 64'(SMOOTH_PART);
  assign beta_prod = {10'd0, segs} * {33'd0, beta};

  assign sts.div_busy    = div_busy;
  assign sts.kind        = kind;
  assign sts.is_ack_grow = grow;
  assign sts.low_path    = low_p;
  assign sts.need_dist   = need_d;

  bic_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_a = {32'd0, cwnd};
    div_b = (seg_sz == 16'd0) ? 32'd1 : {16'd0, seg_sz};
    case (cmd.op)
      OP_SEGDIV: div_start = 1'b1;
      OP_DISTDIV: begin
        div_start = 1'b1;
        div_a = {32'd0, last_max - segs};
        div_b = b_eff;
      end
      OP_CNTDIV: begin
        div_start = 1'b1;
        if (need_d) begin
          if (gap > {32'd0, mi_eff}) begin
            div_a = {32'd0, segs};
            div_b = mi_eff;
          end else if (gap <= 64'd1) begin
            div_a = s_smooth;
            div_b = b_eff;
          end else begin
            div_a = {32'd0, segs};
            div_b = gap[31:0];
          end
        end else begin
          if ({32'd0, segs} < lm_b) begin
            div_a = s_smooth;
            div_b = b_eff;
          end else if ({32'd0, segs} < lm_mib) begin
            div_a = {24'd0, sb_prod};
            div_b = segs - last_max;
          end else begin
            div_a = {32'd0, segs};
            div_b = mi_eff;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_w    <= 32'd10240;
      min_w    <= 32'd5120;
      seg_sz   <= 16'd1448;
      low_segs <= 16'd3;
      max_inc  <= 16'd16;
      sdiv     <= 8'd4;
      beta     <= 9'd205;
      fc_on    <= 1'b1;
      started  <= 1'b0;
      acc      <= '0;
      last_max <= 32'd10240;
      kind     <= KIND_NONE;
      grow     <= 1'b0;
      low_p    <= 1'b0;
      need_d   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_AVG:  avg_w    <= cfg_data;
          REG_MIN:  min_w    <= cfg_data;
          REG_SEG:  seg_sz   <= cfg_data[15:0];
          REG_LOW:  low_segs <= cfg_data[15:0];
          REG_MINC: max_inc  <= cfg_data[15:0];
          REG_DIV:  sdiv     <= cfg_data[7:0];
          REG_BETA: beta     <= cfg_data[8:0];
          REG_FC:   fc_on    <= cfg_data[0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          kind  <= kind_t'(in_data[1:0]);
          cwnd  <= in_data[33:2];
          ssth  <= in_data[65:34];
          acked <= in_data[81:66];
          grow  <= (in_data[1:0] == KIND_ACK) && started &&
                   !(in_data[33:2] < in_data[65:34]) && (in_data[81:66] != 16'd0);
          cnt   <= '0;
        end
        OP_SEGDONE: begin
          segs   <= div_q[31:0];
          low_p  <= div_q[31:0] < {16'd0, low_segs};
          need_d <= div_q[31:0] < last_max;
        end
        OP_DISTDONE: gap <= div_q;
        OP_CNTDONE: cnt <= div_q;
        OP_FINISH: begin
          out_data[95:64] <= 32'd0;
          out_data[63:32] <= ssth;
          out_data[31:0]  <= cwnd;
          case (kind)
            KIND_ACK: begin
              if (!started) begin
                out_data[31:0] <= avg_w;
                started <= 1'b1;
              end else if (cwnd < ssth) begin
                out_data[31:0] <= avg_w;
              end else if (grow) begin
                logic [63:0] c;
                logic [31:0] a32;
                c = low_p ? {32'd0, segs} : cnt;
                if (!low_p) begin
                  if (last_max == 32'd0 && c > {32'd0, CapLowMax}) c = {32'd0, CapLowMax};
                  if (c == 64'd0) c = 64'd1;
                end
                a32 = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
                out_data[95:64] <= a32;
                if (acc + {16'd0, acked} > a32) begin
                  out_data[31:0] <= cwnd + {16'd0, seg_sz};
                  acc <= '0;
                end else begin
                  acc <= acc + {16'd0, acked};
                end
              end
            end
            KIND_LOSS: begin
              if (segs < last_max && fc_on) begin
                last_max <= beta_prod[39:8] | {32{|beta_prod[41:40]}};
              end else begin
                last_max <= segs;
              end
              out_data[63:32] <= min_w;
            end
            KIND_REDUCE: begin
              if (cwnd > avg_w) begin
                out_data[31:0] <= 32'((({1'b0, cwnd} + {1'b0, avg_w}) >> 1));
              end else begin
                logic [31:0] v;
                v = cwnd + ((avg_w - cwnd) >> 1);
                out_data[31:0] <= (v > min_w) ? v : min_w;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/core/bic_ctrl.sv */
// ---------------------------------------------------------------------------
// bic_ctrl
// Controller: sequences divisions and the output register handshake.
// ---------------------------------------------------------------------------
module bic_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bic_pkg::bic_sts_t sts,
  output bic_pkg::bic_cmd_t cmd
);
  import bic_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SEG, S_SEGW, S_PATH, S_DIST, S_DISTW, S_CNT, S_CNTW, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  // result register empty or emptied at this edge
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.op = OP_NONE;
    case (state)
      S_IDLE:  if (in_valid && in_ready) cmd.op = OP_LOAD;
      S_SEG:   cmd.op = OP_SEGDIV;
      S_SEGW:  if (!sts.div_busy) cmd.op = OP_SEGDONE;
      S_DIST:  cmd.op = OP_DISTDIV;
      S_DISTW: if (!sts.div_busy) cmd.op = OP_DISTDONE;
      S_CNT:   cmd.op = OP_CNTDIV;
      S_CNTW:  if (!sts.div_busy) cmd.op = OP_CNTDONE;
      S_FIN:   if (out_free) cmd.op = OP_FINISH;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_valid && in_ready) state <= S_SEG;
        S_SEG:  state <= S_SEGW;
        S_SEGW: if (!sts.div_busy) state <= S_PATH;
        S_PATH: begin
          if (sts.is_ack_grow && !sts.low_path) begin
            state <= sts.need_dist ? S_DIST : S_CNT;
          end else begin
            state <= S_FIN;
          end
        end
        S_DIST:  state <= S_DISTW;
        S_DISTW: if (!sts.div_busy) state <= S_CNT;
        S_CNT:   state <= S_CNTW;
        S_CNTW:  if (!sts.div_busy) state <= S_FIN;
        // hold the finish step while the previous result still waits
        S_FIN:   if (out_free) state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/bic_congestion_window_update_top.sv */
// ---------------------------------------------------------------------------
// bic_congestion_window_update_top
// BIC congestion window update: one result per input event (ACK, loss, reduce or none).
// ---------------------------------------------------------------------------
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready tdata: kind, cwnd, ssthresh, acked
// m_axis    out  m_axis_tvalid/m_axis_tready tdata: cwnd, ssthresh, acks_needed
// cfg       in   cfg_we                      cfg_idx, cfg_data
//
// A loss, reduce, none or non-growing ACK item runs only the segment division;
// a growing ACK at or above the low segment count adds the count division, and
// one below the last maximum also runs the distance division first. Each division
// is 64 steps on one shared bit-serial divider, with start and capture states.
// Synchronous reset restores register defaults and resets the controller and window state.
// Input is taken only when no item is in flight; a stalled result holds in
// the output register while the next item runs up to its finish step.
module bic_congestion_window_update_top #(
  parameter int unsigned SMOOTH_PART = bic_pkg::SmoothPartDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bic_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [bic_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // kind[1:0], cwnd_bytes[33:2], ssthresh_bytes[65:34], acked_segs[81:66]
  input  logic [bic_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // new_cwnd_bytes[31:0], new_ssthresh_bytes[63:32], acks_needed[95:64]
  output logic [bic_pkg::OutDataW-1:0]  m_axis_tdata
);
  import bic_pkg::*;

  bic_cmd_t cmd;
  bic_sts_t sts;

  bic_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .sts(sts), .cmd(cmd)
  );

  bic_dp #(.SMOOTH_PART(SMOOTH_PART)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_data(s_axis_tdata), .cmd(cmd), .sts(sts), .out_data(m_axis_tdata)
  );
endmodule

/* tb/sv/bic_congestion_window_update_top_test.sv */
// ---------------------------------------------------------------------------
// bic_congestion_window_update_top_test
// Self-checking test of the BIC window update block. Events go in on the
// input stream. A model in the test predicts every result, and each output
// transfer is checked against the oldest prediction. The test runs under
// several register settings and random stalls on both sides, and one pass without stalls.
// ---------------------------------------------------------------------------
module bic_congestion_window_update_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bic_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [31:0] cwnd;
    logic [31:0] ssth;
    logic [31:0] acks;
  } window_update_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  bic_congestion_window_update_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // model registers and state
  logic [31:0] avg_win, min_win, last_max, ack_acc;
  logic [15:0] seg_size, low_segs, max_inc;
  logic [7:0]  srch_div;
  logic [8:0]  beta;
  logic        fc_on, started;

  window_update_t expected_updates[$];
  int unsigned    mismatches;
  int unsigned    cycles;
  bit             no_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 19);
  end

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] segments_of(logic [31:0] cwnd);
    logic [31:0] ss;
    ss = (seg_size == 0) ? 32'd1 : {16'd0, seg_size};
    return cwnd / ss;
  endfunction

  function automatic logic [31:0] acks_per_segment(logic [31:0] seg);
    logic [63:0] b, mi, s, lm, cnt, gap;
    b = (srch_div < 2) ? 64'd2 : 64'(srch_div);
    mi = (max_inc == 0) ? 64'd1 : 64'(max_inc);
    s = 64'(seg);
    lm = 64'(last_max);
    if (seg < 32'(low_segs)) return seg;
    if (s < lm) begin
      gap = (lm - s) / b;
      if (gap > mi) cnt = s / mi;
      else if (gap <= 1) cnt = (s * SmoothPartDefault) / b;
      else cnt = s / gap;
    end else begin
      if (s < lm + b) cnt = (s * SmoothPartDefault) / b;
      else if (s < lm + mi * (b - 1)) cnt = (s * (b - 1)) / (s - lm);
      else cnt = s / mi;
    end
    if (lm == 0 && cnt > 20) cnt = 64'd20;
    if (cnt == 0) cnt = 64'd1;
    return sat32(cnt);
  endfunction

  function automatic window_update_t predict_update(kind_t kind, logic [31:0] cwnd,
                                                    logic [31:0] ssth, logic [15:0] acked);
    window_update_t r;
    logic [31:0] seg, v;
    logic [32:0] sum;
    r.cwnd = cwnd;
    r.ssth = ssth;
    r.acks = 32'd0;
    case (kind)
      KIND_ACK: begin
        if (!started) begin
          r.cwnd = avg_win;
          started = 1'b1;
        end else if (cwnd < ssth) begin
          r.cwnd = avg_win;
        end else if (acked > 0) begin
          ack_acc = ack_acc + 32'(acked);
          r.acks = acks_per_segment(segments_of(cwnd));
          if (ack_acc > r.acks) begin
            r.cwnd = cwnd + 32'(seg_size);
            ack_acc = 32'd0;
          end
        end
      end
      KIND_LOSS: begin
        seg = segments_of(cwnd);
        if (seg < last_max && fc_on) last_max = sat32((64'(seg) * 64'(beta)) >> 8);
        else last_max = seg;
        r.ssth = min_win;
      end
      KIND_REDUCE: begin
        if (cwnd > avg_win) begin
          sum = 33'(cwnd) + 33'(avg_win);
          r.cwnd = sum[32:1];
        end else begin
          v = cwnd + ((avg_win - cwnd) >> 1);
          r.cwnd = (v > min_win) ? v : min_win;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    window_update_t exp_r, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.cwnd = m_axis_tdata[31:0];
      got.ssth = m_axis_tdata[63:32];
      got.acks = m_axis_tdata[95:64];
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h", m_axis_tdata);
      end else begin
        exp_r = expected_updates.pop_front();
        if (got != exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cwnd %h ssth %h acks %h, got cwnd %h ssth %h acks %h",
                     exp_r.cwnd, exp_r.ssth, exp_r.acks, got.cwnd, got.ssth, got.acks);
        end
      end
    end
  end

  task automatic send_event(kind_t kind, logic [31:0] cwnd, logic [31:0] ssth,
                            logic [15:0] acked);
    while (!no_idle && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, acked, ssth, cwnd, kind};
    do @(posedge clk); while (!s_axis_tready);
    expected_updates.push_back(predict_update(kind, cwnd, ssth, acked));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_AVG:  avg_win = data;
      REG_MIN:  min_win = data;
      REG_SEG:  seg_size = data[15:0];
      REG_LOW:  low_segs = data[15:0];
      REG_MINC: max_inc = data[15:0];
      REG_DIV:  srch_div = data[7:0];
      REG_BETA: beta = data[8:0];
      default:  fc_on = data[0];
    endcase
  endtask

  // upper bits carry junk at times; the block keeps only the register width
  task automatic write_all(logic [31:0] avg, logic [31:0] mn, logic [15:0] seg,
                           logic [15:0] low, logic [15:0] minc, logic [7:0] dv,
                           logic [8:0] bt, logic fc);
    logic [31:0] junk;
    junk = ($urandom_range(1) == 1) ? $urandom : 32'd0;
    write_reg(REG_AVG, avg);
    write_reg(REG_MIN, mn);
    write_reg(REG_SEG, {junk[31:16], seg});
    write_reg(REG_LOW, {junk[31:16], low});
    write_reg(REG_MINC, {junk[31:16], minc});
    write_reg(REG_DIV, {junk[31:8], dv});
    write_reg(REG_BETA, {junk[31:9], bt});
    write_reg(REG_FC, {junk[31:1], fc});
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_event;
    logic [63:0] c;
    logic [31:0] cwnd, ssth, ss;
    logic [15:0] acked;
    int sel, delta;
    sel = $urandom_range(99);
    ss = (seg_size == 0) ? 32'd1 : 32'(seg_size);
    delta = $urandom_range(80) - 40;
    c = (64'(last_max) + 64'($signed(delta))) * 64'(ss) + 64'($urandom_range(ss - 1));
    if ($urandom_range(3) == 0) c = 64'($urandom_range(200)) * 64'(ss);
    if (last_max < 40 && delta < 0) c = 64'($urandom_range(60)) * 64'(ss);
    cwnd = sat32(c);
    ssth = ($urandom_range(9) == 0) ? cwnd + 32'd1 : cwnd - 32'($urandom_range(1000));
    if (ssth > cwnd) ssth = ($urandom_range(9) == 0) ? ssth : 0;
    acked = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
    if (sel < 60) send_event(KIND_ACK, cwnd, ssth, acked);
    else if (sel < 72) send_event(KIND_LOSS, cwnd, ssth, acked);
    else if (sel < 84) send_event(KIND_REDUCE, cwnd, ssth, acked);
    else if (sel < 88) send_event(KIND_NONE, cwnd, ssth, acked);
    else send_event(kind_t'($urandom_range(3)), $urandom, $urandom, 16'($urandom));
  endtask

  task automatic run_random(int n);
    repeat (n) send_random_event();
    drain();
  endtask

  task automatic test_directed;
    send_event(KIND_ACK, 32'hFFFF_FFFF, 32'd0, 16'd0);       // first ack starts
    send_event(KIND_ACK, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);    // below threshold
    send_event(KIND_ACK, 32'd14480, 32'd0, 16'd0);           // zero segments acked
    send_event(KIND_ACK, 32'd14480, 32'd0, 16'd1);
    send_event(KIND_ACK, 32'd14480, 32'd0, 16'hFFFF);
    send_event(KIND_ACK, 32'd2000, 32'd0, 16'd5);            // below low count
    send_event(KIND_ACK, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);    // largest window, no growth
    send_event(KIND_LOSS, 32'd144800, 32'd7, 16'd0);
    send_event(KIND_ACK, 32'd144800, 32'd0, 16'd3);
    send_event(KIND_ACK, 32'd150000, 32'd0, 16'd3);
    send_event(KIND_ACK, 32'd300000, 32'd0, 16'd3);
    send_event(KIND_LOSS, 32'd0, 32'hFFFF_FFFF, 16'd0);      // last max to zero
    send_event(KIND_ACK, 32'd100000, 32'd0, 16'd2);          // zero last max, count under the cap
    send_event(KIND_LOSS, 32'hFFFF_FFFF, 32'd0, 16'd0);
    send_event(KIND_LOSS, 32'd1448, 32'd0, 16'd0);           // fast convergence
    send_event(KIND_REDUCE, 32'hFFFF_FFFF, 32'd1, 16'd0);
    send_event(KIND_REDUCE, 32'd10241, 32'd1, 16'd0);
    send_event(KIND_REDUCE, 32'd10240, 32'd1, 16'd0);
    send_event(KIND_REDUCE, 32'd0, 32'd1, 16'd0);            // floored at minimum
    send_event(KIND_REDUCE, 32'd9000, 32'd1, 16'd0);
    send_event(KIND_NONE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'hFFFF);
    drain();
  endtask

  task automatic test_default_settings;
    run_random(150);
  endtask

  task automatic test_no_idle;
    no_idle = 1'b1;
    run_random(150);
    no_idle = 1'b0;
  endtask

  task automatic test_register_extremes;
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'd0, 16'd1, 8'd2, 9'd256, 1'b1);
    run_random(120);
    write_all(32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 9'd0, 1'b0);
    run_random(120);
    write_all(32'd4096, 32'd8192, 16'd0, 16'd0, 16'd0, 8'd0, 9'd1, 1'b1);
    run_random(120);
    write_all(32'd20000, 32'd1000, 16'd512, 16'd1, 16'd4, 8'd1, 9'h1FF, 1'b1);
    run_random(120);
    write_all(32'd30000, 32'd2000, 16'd100, 16'd0, 16'd2000, 8'd3, 9'd128, 1'b0);
    run_random(120);
  endtask

  task automatic test_random_settings;
    repeat (5) begin
      write_all($urandom_range(200000), $urandom_range(50000), 16'($urandom_range(2000, 1)),
                16'($urandom_range(8)), 16'($urandom_range(64, 1)),
                8'($urandom_range(16, 2)), 9'($urandom_range(256)), 1'($urandom));
      run_random(110);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cycles = 0;
    mismatches = 0;
    no_idle = 1'b0;
    avg_win = 32'd10240;
    min_win = 32'd5120;
    seg_size = 16'd1448;
    low_segs = 16'd3;
    max_inc = 16'd16;
    srch_div = 8'd4;
    beta = 9'd205;
    fc_on = 1'b1;
    started = 1'b0;
    ack_acc = 32'd0;
    last_max = 32'd10240;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_default_settings();
    test_no_idle();
    test_register_extremes();
    test_random_settings();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
